FILE: rtl/snt_pkg.sv
// Shared types and constants for the sensor node table.
// No dependencies; sensor_node_table_update and snt_cell use this package by scoped names.
`timescale 1ns / 1ps

package snt_pkg;

	localparam int IDX_W = 8;

	typedef enum logic [2:0] {
		OP_SENSOR  = 3'd0,
		OP_BUTTON  = 3'd1,
		OP_ACTUATE = 3'd2,
		OP_SET     = 3'd3,
		OP_CMD     = 3'd4,
		OP_ACK     = 3'd5,
		OP_TIMEOUT = 3'd6,
		OP_LOOKUP  = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// search token walking down the cell row
	typedef struct packed {
		logic             vld;
		opcode_t          op;
		logic [1:0]       tr;
		logic [63:0]      hi;
		logic [63:0]      lo;
		logic             seq_pres;
		logic [31:0]      arg;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [31:0]      gap;
	} probe_t;

endpackage

FILE: rtl/snt_if.sv
// Event and result channel interfaces for the sensor node table.
// Depends on nothing; ready/valid transfer on each.
`timescale 1ns / 1ps

interface snt_event_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [1:0]         transport;
	logic [63:0]        addr_hi;
	logic [63:0]        addr_lo;
	logic [39:0]        time_ms;
	logic [1:0]         meta_valid;
	logic signed [7:0]  link_rssi;
	logic [7:0]         hop_count;
	logic [12:0]        present_mask;
	logic signed [31:0] argument;
	logic [1:0]         flags;

	modport source (output valid, opcode, transport, addr_hi, addr_lo, time_ms, meta_valid,
		link_rssi, hop_count, present_mask, argument, flags, input ready);
	modport sink (input valid, opcode, transport, addr_hi, addr_lo, time_ms, meta_valid,
		link_rssi, hop_count, present_mask, argument, flags, output ready);
endinterface

interface snt_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  node_index;
	logic        created;
	logic [31:0] gap_added;

	modport source (output valid, status, node_index, created, gap_added, input ready);
	modport sink (input valid, status, node_index, created, gap_added, output ready);
endinterface

FILE: rtl/sensor_node_table_update.sv
// Top level of the sensor node table: cell row, result stage, entry count.
// Depends on snt_pkg, snt_if (snt_event_if, snt_result_if) and snt_cell.
`timescale 1ns / 1ps

//  channel    | dir | transfer
//  event_ch   | in  | one event (opcode, key, time, link meta, mask, argument, flags)
//  result_ch  | out | one result per event (status, node_index, created, gap_added)
//
// Path: the event is registered in the launch register at the transfer edge, then
//   passes one cell of the search row per cycle, then the tail register and the
//   result register.
// One event is in the row at a time; the next is taken once the result is loaded,
//   even while that result still waits on result_ch.
// Reset clears the entry count and all valid flags; slot contents need no clear.
// A stalled result holds the finished search in the tail register.
module sensor_node_table_update #(
	parameter int NODE_SLOTS = 32
) (
	input logic          clk,
	input logic          arst_n,
	snt_event_if.sink    event_ch,
	snt_result_if.source result_ch
);

	localparam int IW = snt_pkg::IDX_W;

	snt_pkg::probe_t chain [NODE_SLOTS+1];
	snt_pkg::probe_t launch_q;
	snt_pkg::probe_t tail_q;

	logic          busy_q;
	logic          tail_vld_q;
	logic          out_vld_q;
	logic [IW-1:0] count_q;

	logic                 accept;
	logic                 load;
	logic                 create;
	snt_pkg::status_t     res_status;
	logic [IW-1:0]        res_idx;
	logic [31:0]          res_gap;

	snt_pkg::status_t status_q;
	logic [IW-1:0]    idx_q;
	logic             created_q;
	logic [31:0]      gap_q;

	assign event_ch.ready = !busy_q;
	assign accept = event_ch.valid && !busy_q;

	// launch register feeds cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q.vld <= 1'b0;
		end else begin
			launch_q.vld      <= accept;
			launch_q.op       <= snt_pkg::opcode_t'(event_ch.opcode);
			launch_q.tr       <= event_ch.transport;
			launch_q.hi       <= event_ch.addr_hi;
			launch_q.lo       <= event_ch.addr_lo;
			launch_q.seq_pres <= event_ch.present_mask[0];
			launch_q.arg      <= event_ch.argument;
			launch_q.found    <= 1'b0;
			launch_q.idx      <= '0;
			launch_q.gap      <= '0;
		end
	end

	assign chain[0] = launch_q;

	for (genvar k = 0; k < NODE_SLOTS; k++) begin : g_cell
		snt_cell #(.INDEX(k)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.live  (IW'(k) < count_q),
			.wr_en (create && count_q == IW'(k)),
			.wr_p  (tail_q),
			.p_in  (chain[k]),
			.p_out (chain[k+1])
		);
	end

	// result decision on the finished search
	always_comb begin
		create     = 1'b0;
		res_status = snt_pkg::ST_OK;
		res_idx    = '0;
		res_gap    = '0;
		if (tail_q.found) begin
			res_idx = tail_q.idx;
			res_gap = tail_q.gap;
		end else if (tail_q.op == snt_pkg::OP_LOOKUP) begin
			res_status = snt_pkg::ST_NOT_FOUND;
		end else if (count_q < IW'(NODE_SLOTS)) begin
			create  = load;
			res_idx = count_q;
		end else begin
			res_status = snt_pkg::ST_FULL;
		end
	end

	assign load = tail_vld_q && (!out_vld_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			tail_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			count_q    <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (chain[NODE_SLOTS].vld) begin
				tail_vld_q <= 1'b1;
			end else if (load) begin
				tail_vld_q <= 1'b0;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			if (create) begin
				count_q <= count_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain[NODE_SLOTS].vld) begin
			tail_q <= chain[NODE_SLOTS];
		end
		if (load) begin
			status_q  <= res_status;
			idx_q     <= res_idx;
			created_q <= !tail_q.found && create;
			gap_q     <= res_gap;
		end
	end

	assign result_ch.valid      = out_vld_q;
	assign result_ch.status     = status_q;
	assign result_ch.node_index = idx_q;
	assign result_ch.created    = created_q;
	assign result_ch.gap_added  = gap_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IW'(NODE_SLOTS))
		else $error("entry count above slot count");

	a_create_count: assert property (@(posedge clk) disable iff (!arst_n)
		create |=> count_q == $past(count_q) + IW'(1))
		else $error("append did not bump entry count");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld_q |-> busy_q)
		else $error("finished search with no event in flight");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && status_q != snt_pkg::ST_OK |-> idx_q == '0 && !created_q && gap_q == '0)
		else $error("error result carries node data");

endmodule

FILE: rtl/snt_cell.sv
// One table slot: node key and sequence tracking, plus one stage of the search row.
// Depends on snt_pkg.
`timescale 1ns / 1ps

module snt_cell #(
	parameter int INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          live,
	input  logic          wr_en,
	input  snt_pkg::probe_t wr_p,
	input  snt_pkg::probe_t p_in,
	output snt_pkg::probe_t p_out
);

	logic [1:0]  key_tr_q;
	logic [63:0] key_hi_q;
	logic [63:0] key_lo_q;
	logic        has_seq_q;
	logic [31:0] last_seq_q;

	snt_pkg::probe_t p_q;
	snt_pkg::probe_t p_nxt;
	logic            hit;
	logic            seq_upd;
	logic [31:0]     diff;

	assign hit = p_in.vld && !p_in.found && live && key_tr_q == p_in.tr
		&& key_hi_q == p_in.hi && key_lo_q == p_in.lo;
	assign seq_upd = hit && p_in.op == snt_pkg::OP_SENSOR && p_in.seq_pres;
	assign diff = p_in.arg - (last_seq_q + 32'd1);

	always_comb begin
		p_nxt = p_in;
		if (hit) begin
			p_nxt.found = 1'b1;
			p_nxt.idx   = snt_pkg::IDX_W'(INDEX);
			// only forward gaps count
			if (seq_upd && has_seq_q && diff != 32'd0 && !diff[31]) begin
				p_nxt.gap = diff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q.vld <= 1'b0;
		end else begin
			p_q <= p_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_tr_q   <= wr_p.tr;
			key_hi_q   <= wr_p.hi;
			key_lo_q   <= wr_p.lo;
			has_seq_q  <= wr_p.op == snt_pkg::OP_SENSOR && wr_p.seq_pres;
			last_seq_q <= wr_p.arg;
		end else if (seq_upd) begin
			has_seq_q  <= 1'b1;
			last_seq_q <= p_in.arg;
		end
	end

	assign p_out = p_q;

endmodule
